// ===== design/wss_pkg.sv =====
// ----------------------------------------------------------------------------
// Window sender package
// Shared widths, codes, reset values and control structs of the window
// sender segmenter.
// ----------------------------------------------------------------------------
package wss_pkg;

	localparam int BURST_LIMIT_DEF = 16;

	localparam int SEQ_W      = 32;
	localparam int WIN_W      = 16;
	localparam int LEN_W      = 11;
	localparam int RETRY_W    = 4;
	localparam int MODE_W     = 2;
	localparam int KIND_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [MODE_W-1:0] MODE_START    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ACK      = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PEER_RST = 2'd2;
	localparam logic [MODE_W-1:0] MODE_TIMEOUT  = 2'd3;

	typedef enum logic [KIND_W-1:0] {
		KIND_DATA       = 3'd0,
		KIND_RST_SENT   = 3'd1,
		KIND_NEW_ACK    = 3'd2,
		KIND_DUP_ACK    = 3'd3,
		KIND_COMPLETE   = 3'd4,
		KIND_PEER_ABORT = 3'd5,
		KIND_IGNORED    = 3'd6
	} kind_t;

	localparam logic [CFG_IDX_W-1:0] CFG_FILE_LENGTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_SEQUENCE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_WINDOW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT    = 3'd4;

	localparam logic [WIN_W-1:0]   INIT_WINDOW_RST = 16'd10240;
	localparam logic [LEN_W-1:0]   MAX_PAYLOAD_RST = 11'd959;
	localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 4'd3;
	localparam logic [LEN_W-1:0]   MAX_PAY_CAP     = 11'd1024;
	localparam logic [RETRY_W-1:0] RETRY_MAX       = 4'd15;

	typedef struct packed {
		logic latch_in;
		logic exec;
		logic calc_rem;
		logic prep;
		logic emit_status;
		logic emit_seg;
		logic emit_cpl;
	} ctl_cmd_t;

	typedef struct packed {
		logic do_round;
		logic has_status;
		logic rem_zero;
		logic rmd_zero;
		logic status_last;
		logic seg_last;
		logic slot_free;
	} dp_stat_t;

endpackage

// ===== design/wss_evt_if.sv =====
// ----------------------------------------------------------------------------
// Event channel
// Carries one input event per transaction: mode, ack number and window.
// ----------------------------------------------------------------------------
interface wss_evt_if;
	import wss_pkg::*;

	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [SEQ_W-1:0]  ack_number;
	logic [WIN_W-1:0]  ack_window;

	modport source (output valid, output mode, output ack_number, output ack_window,
		input ready);
	modport sink (input valid, input mode, input ack_number, input ack_window,
		output ready);
endinterface

// ===== design/wss_res_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Carries one result item per transaction.
// ----------------------------------------------------------------------------
interface wss_res_if;
	import wss_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [SEQ_W-1:0]  seq_number;
	logic [LEN_W-1:0]  payload_len;
	logic              retransmit;
	logic              last;

	modport source (output valid, output kind, output seq_number, output payload_len,
		output retransmit, output last, input ready);
	modport sink (input valid, input kind, input seq_number, input payload_len,
		input retransmit, input last, output ready);
endinterface

// ===== design/wss_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries one register write per transaction: register index and data.
// ----------------------------------------------------------------------------
interface wss_cfg_if;
	import wss_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/wss_ctrl.sv =====
// ----------------------------------------------------------------------------
// Window sender controller
// Sequences event evaluation, round setup and result emission.
// ----------------------------------------------------------------------------
module wss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              evt_valid,
	output logic              evt_ready,
	input  wss_pkg::dp_stat_t stat,
	output wss_pkg::ctl_cmd_t cmd
);
	import wss_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_EXEC   = 7'b0000010,
		ST_REM    = 7'b0000100,
		ST_PREP   = 7'b0001000,
		ST_STATUS = 7'b0010000,
		ST_BURST  = 7'b0100000,
		ST_CPL    = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	state_t after_status;

	always_comb begin
		if (!stat.do_round) begin
			after_status = ST_IDLE;
		end else if (stat.rem_zero) begin
			after_status = ST_CPL;
		end else if (stat.rmd_zero) begin
			after_status = ST_IDLE;
		end else begin
			after_status = ST_BURST;
		end
	end

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		evt_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				evt_ready = 1'b1;
				if (evt_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_REM;
			end
			ST_REM: begin
				if (stat.do_round) begin
					cmd.calc_rem = 1'b1;
					state_d      = ST_PREP;
				end else begin
					state_d = ST_STATUS;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_STATUS;
			end
			ST_STATUS: begin
				if (!stat.has_status) begin
					state_d = after_status;
				end else if (stat.slot_free) begin
					cmd.emit_status = 1'b1;
					state_d         = after_status;
				end
			end
			ST_BURST: begin
				if (stat.slot_free) begin
					cmd.emit_seg = 1'b1;
					if (stat.seg_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_CPL: begin
				if (stat.slot_free) begin
					cmd.emit_cpl = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ===== design/wss_datapath.sv =====
// ----------------------------------------------------------------------------
// Window sender datapath
// Configuration and transfer state, round setup, segment stepping and the
// output register.
// ----------------------------------------------------------------------------
module wss_datapath #(
	parameter int BURST_LIMIT = wss_pkg::BURST_LIMIT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  wss_pkg::ctl_cmd_t              cmd,
	output wss_pkg::dp_stat_t              stat,
	input  logic [wss_pkg::MODE_W-1:0]     evt_mode,
	input  logic [wss_pkg::SEQ_W-1:0]      evt_ack_number,
	input  logic [wss_pkg::WIN_W-1:0]      evt_ack_window,
	input  logic                           cfg_we,
	input  logic [wss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wss_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           res_ready,
	output logic                           res_valid,
	output logic [wss_pkg::KIND_W-1:0]     res_kind,
	output logic [wss_pkg::SEQ_W-1:0]      res_seq_number,
	output logic [wss_pkg::LEN_W-1:0]      res_payload_len,
	output logic                           res_retransmit,
	output logic                           res_last
);
	import wss_pkg::*;

	localparam int CNT_W = $clog2(BURST_LIMIT + 1);

	logic [SEQ_W-1:0]   file_length_q;
	logic [SEQ_W-1:0]   start_sequence_q;
	logic [WIN_W-1:0]   initial_window_q;
	logic [LEN_W-1:0]   max_payload_q;
	logic [RETRY_W-1:0] retry_limit_q;

	logic [SEQ_W-1:0]   next_unacked_q;
	logic [WIN_W-1:0]   cur_window_q;
	logic [SEQ_W-1:0]   acked_bytes_q;
	logic [SEQ_W-1:0]   highest_sent_q;
	logic [SEQ_W-1:0]   burst_end_q;
	logic               heard_q;
	logic [RETRY_W-1:0] retry_count_q;
	logic               phase_q;

	logic [MODE_W-1:0]  mode_q;
	logic [SEQ_W-1:0]   ack_number_q;
	logic [WIN_W-1:0]   ack_window_q;

	logic               do_round_q;
	logic               has_status_q;
	logic [KIND_W-1:0]  status_kind_q;
	logic [SEQ_W-1:0]   rem_q;
	logic [SEQ_W-1:0]   rmd_q;
	logic [SEQ_W-1:0]   seq_q;
	logic [LEN_W-1:0]   mp_q;
	logic [CNT_W-1:0]   cnt_q;

	logic               out_valid_q;
	logic [KIND_W-1:0]  out_kind_q;
	logic [SEQ_W-1:0]   out_seq_q;
	logic [LEN_W-1:0]   out_len_q;
	logic               out_rt_q;
	logic               out_last_q;

	logic [SEQ_W-1:0]   ack_delta;
	logic               ack_after;
	logic [RETRY_W-1:0] retry_next;
	logic [LEN_W-1:0]   mp_clamped;
	logic [LEN_W-1:0]   pay;
	logic [SEQ_W-1:0]   pay_ext;
	logic [SEQ_W-1:0]   seq_delta;
	logic               seg_new;
	logic               seg_last;
	logic               rem_zero;
	logic               rmd_zero;
	logic               emit_any;

	assign ack_delta = ack_number_q - next_unacked_q;
	assign ack_after = (ack_delta != '0) && !ack_delta[SEQ_W-1];

	always_comb begin
		if (heard_q) begin
			retry_next = '0;
		end else if (retry_count_q < RETRY_MAX) begin
			retry_next = retry_count_q + 1'b1;
		end else begin
			retry_next = retry_count_q;
		end
	end

	always_comb begin
		if (max_payload_q == '0) begin
			mp_clamped = LEN_W'(1);
		end else if (max_payload_q > MAX_PAY_CAP) begin
			mp_clamped = MAX_PAY_CAP;
		end else begin
			mp_clamped = max_payload_q;
		end
	end

	assign pay       = (rmd_q < {{(SEQ_W-LEN_W){1'b0}}, mp_q}) ? rmd_q[LEN_W-1:0] : mp_q;
	assign pay_ext   = {{(SEQ_W-LEN_W){1'b0}}, pay};
	assign seq_delta = seq_q - highest_sent_q;
	assign seg_new   = (seq_delta != '0) && !seq_delta[SEQ_W-1];
	assign seg_last  = (rmd_q == pay_ext) || (cnt_q == CNT_W'(BURST_LIMIT - 1));
	assign rem_zero  = (rem_q == '0);
	assign rmd_zero  = (rmd_q == '0);
	assign emit_any  = cmd.emit_status || cmd.emit_seg || cmd.emit_cpl;

	assign stat.do_round    = do_round_q;
	assign stat.has_status  = has_status_q;
	assign stat.rem_zero    = rem_zero;
	assign stat.rmd_zero    = rmd_zero;
	assign stat.status_last = !do_round_q || (!rem_zero && rmd_zero);
	assign stat.seg_last    = seg_last;
	assign stat.slot_free   = !out_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q    <= '0;
			start_sequence_q <= '0;
			initial_window_q <= INIT_WINDOW_RST;
			max_payload_q    <= MAX_PAYLOAD_RST;
			retry_limit_q    <= RETRY_LIMIT_RST;
			next_unacked_q   <= '0;
			cur_window_q     <= '0;
			acked_bytes_q    <= '0;
			highest_sent_q   <= '0;
			burst_end_q      <= '0;
			heard_q          <= 1'b0;
			retry_count_q    <= '0;
			phase_q          <= 1'b0;
			do_round_q       <= 1'b0;
			has_status_q     <= 1'b0;
			status_kind_q    <= KIND_IGNORED;
			rem_q            <= '0;
			rmd_q            <= '0;
			seq_q            <= '0;
			mp_q             <= '0;
			cnt_q            <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FILE_LENGTH:    file_length_q    <= cfg_data;
					CFG_START_SEQUENCE: start_sequence_q <= cfg_data;
					CFG_INITIAL_WINDOW: initial_window_q <= cfg_data[WIN_W-1:0];
					CFG_MAX_PAYLOAD:    max_payload_q    <= cfg_data[LEN_W-1:0];
					CFG_RETRY_LIMIT:    retry_limit_q    <= cfg_data[RETRY_W-1:0];
					default: begin
					end
				endcase
			end

			if (cmd.exec) begin
				do_round_q   <= 1'b0;
				has_status_q <= 1'b1;
				if (mode_q == MODE_START) begin
					next_unacked_q <= start_sequence_q;
					highest_sent_q <= start_sequence_q - 1'b1;
					cur_window_q   <= initial_window_q;
					acked_bytes_q  <= '0;
					burst_end_q    <= start_sequence_q;
					heard_q        <= 1'b0;
					retry_count_q  <= '0;
					phase_q        <= 1'b1;
					do_round_q     <= 1'b1;
					has_status_q   <= 1'b0;
				end else if (!phase_q) begin
					status_kind_q <= KIND_IGNORED;
				end else begin
					case (mode_q)
						MODE_ACK: begin
							heard_q <= 1'b1;
							if (ack_after) begin
								acked_bytes_q  <= acked_bytes_q + ack_delta;
								next_unacked_q <= ack_number_q;
								cur_window_q   <= ack_window_q;
								status_kind_q  <= KIND_NEW_ACK;
								if (ack_number_q == burst_end_q) begin
									heard_q       <= 1'b0;
									retry_count_q <= '0;
									do_round_q    <= 1'b1;
								end
							end else begin
								status_kind_q <= KIND_DUP_ACK;
							end
						end
						MODE_PEER_RST: begin
							phase_q       <= 1'b0;
							status_kind_q <= KIND_PEER_ABORT;
						end
						MODE_TIMEOUT: begin
							retry_count_q <= retry_next;
							heard_q       <= 1'b0;
							if (retry_next >= retry_limit_q) begin
								phase_q       <= 1'b0;
								status_kind_q <= KIND_RST_SENT;
							end else begin
								do_round_q   <= 1'b1;
								has_status_q <= 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
			end

			if (cmd.calc_rem) begin
				rem_q <= (acked_bytes_q >= file_length_q) ? '0 : file_length_q - acked_bytes_q;
			end

			if (cmd.prep) begin
				rmd_q       <= ({{(SEQ_W-WIN_W){1'b0}}, cur_window_q} < rem_q) ?
					{{(SEQ_W-WIN_W){1'b0}}, cur_window_q} : rem_q;
				seq_q       <= next_unacked_q;
				burst_end_q <= next_unacked_q;
				cnt_q       <= '0;
				mp_q        <= mp_clamped;
				if (rem_zero) begin
					phase_q <= 1'b0;
				end
			end

			if (cmd.emit_seg) begin
				rmd_q       <= rmd_q - pay_ext;
				seq_q       <= seq_q + pay_ext;
				burst_end_q <= seq_q + pay_ext;
				cnt_q       <= cnt_q + 1'b1;
				if (seg_new) begin
					highest_sent_q <= seq_q;
				end
			end

			if (emit_any) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			mode_q       <= evt_mode;
			ack_number_q <= evt_ack_number;
			ack_window_q <= evt_ack_window;
		end
		if (cmd.emit_status) begin
			out_kind_q <= status_kind_q;
			out_seq_q  <= '0;
			out_len_q  <= '0;
			out_rt_q   <= 1'b0;
			out_last_q <= stat.status_last;
		end else if (cmd.emit_seg) begin
			out_kind_q <= KIND_DATA;
			out_seq_q  <= seq_q;
			out_len_q  <= pay;
			out_rt_q   <= !seg_new;
			out_last_q <= seg_last;
		end else if (cmd.emit_cpl) begin
			out_kind_q <= KIND_COMPLETE;
			out_seq_q  <= '0;
			out_len_q  <= '0;
			out_rt_q   <= 1'b0;
			out_last_q <= 1'b1;
		end
	end

	assign res_valid       = out_valid_q;
	assign res_kind        = out_kind_q;
	assign res_seq_number  = out_seq_q;
	assign res_payload_len = out_len_q;
	assign res_retransmit  = out_rt_q;
	assign res_last        = out_last_q;
endmodule

// ===== design/window_sender_segmenter.sv =====
// ----------------------------------------------------------------------------
// Window sender segmenter
// Data-phase sender of a windowed go-back-N transfer that turns start,
// acknowledgement, peer reset and timeout events into segment descriptors
// and status results.
// ----------------------------------------------------------------------------
// One event is taken at a time. After the accepting cycle an event passes
// through the evaluation steps, execute and then remainder, then a round setup
// step when it opens a round, then a status step, which waits for a free
// output slot when it has a status result to emit. A round then emits one
// data segment or completion result per cycle while the result channel is
// ready, at most BURST_LIMIT segments per round. Results leave through the
// single output register, which the segment step fills with one descriptor
// per cycle while it is free. Configuration writes are always accepted and
// must only be issued while no event is in progress.
module window_sender_segmenter #(
	parameter int BURST_LIMIT = wss_pkg::BURST_LIMIT_DEF
) (
	input logic clk,
	input logic arst_n,
	wss_evt_if.sink   evt,
	wss_res_if.source result,
	wss_cfg_if.sink   cfg
);
	import wss_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	assign cfg.ready = 1'b1;

	wss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt.valid),
		.evt_ready (evt.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	wss_datapath #(
		.BURST_LIMIT (BURST_LIMIT)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.evt_mode        (evt.mode),
		.evt_ack_number  (evt.ack_number),
		.evt_ack_window  (evt.ack_window),
		.cfg_we          (cfg.valid),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.res_ready       (result.ready),
		.res_valid       (result.valid),
		.res_kind        (result.kind),
		.res_seq_number  (result.seq_number),
		.res_payload_len (result.payload_len),
		.res_retransmit  (result.retransmit),
		.res_last        (result.last)
	);

	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid && evt.ready |=> !evt.ready)
		else $error("event accepted while the previous one is in progress");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.kind != KIND_DATA) |->
		(result.seq_number == '0) && (result.payload_len == '0) && !result.retransmit)
		else $error("status result carries segment fields");

	a_seg_len: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.kind == KIND_DATA) |->
		(result.payload_len != '0) && (result.payload_len <= MAX_PAY_CAP))
		else $error("data segment length out of range");

	a_cpl_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && ((result.kind == KIND_COMPLETE) || (result.kind == KIND_IGNORED) ||
		(result.kind == KIND_PEER_ABORT) || (result.kind == KIND_RST_SENT)) |-> result.last)
		else $error("terminal status result not marked last");
endmodule

// ===== tb/tb_window_sender_segmenter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window sender segmenter testbench
// Drives start, acknowledgement, peer reset and timeout events into the
// sender, first from a short directed table, then as random transfers under
// many register settings. Every result transaction is checked field by field
// against an in-order queue filled by a sender model, with random idle cycles
// on the event side and random back-pressure on the result side.
// ----------------------------------------------------------------------------
module tb_window_sender_segmenter;
	import wss_pkg::*;

	localparam int SEG_LIMIT      = BURST_LIMIT_DEF;
	localparam int QUIET_CYCLES   = 32;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 335;
	localparam int DIR_STEPS      = 25;

	typedef struct {
		kind_t            kind;
		logic [SEQ_W-1:0] seq;
		logic [LEN_W-1:0] len;
		logic             rexmit;
		logic             last;
	} sender_result_t;

	typedef struct {
		int                phase;
		logic [MODE_W-1:0] mode;
		logic [SEQ_W-1:0]  ackn;
		logic [WIN_W-1:0]  ackw;
		bit                fixed;
		kind_t             kind;
	} dir_step_t;

	typedef struct {
		logic [CFG_DATA_W-1:0] file_len;
		logic [CFG_DATA_W-1:0] start_seq;
		logic [CFG_DATA_W-1:0] init_win;
		logic [CFG_DATA_W-1:0] max_pay;
		logic [CFG_DATA_W-1:0] retry_lim;
	} reg_set_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	wss_evt_if evt_ch ();
	wss_res_if res_ch ();
	wss_cfg_if cfg_ch ();

	window_sender_segmenter #(.BURST_LIMIT(SEG_LIMIT)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Register copies and sender state of the model.
	logic [SEQ_W-1:0]   cfg_file_len  = '0;
	logic [SEQ_W-1:0]   cfg_start_seq = '0;
	logic [WIN_W-1:0]   cfg_init_win  = INIT_WINDOW_RST;
	logic [LEN_W-1:0]   cfg_max_pay   = MAX_PAYLOAD_RST;
	logic [RETRY_W-1:0] cfg_retry_lim = RETRY_LIMIT_RST;

	logic [SEQ_W-1:0]   model_next      = '0;
	logic [WIN_W-1:0]   model_window    = '0;
	logic [SEQ_W-1:0]   model_acked     = '0;
	logic [SEQ_W-1:0]   model_highest   = '0;
	logic [SEQ_W-1:0]   model_burst_end = '0;
	logic               model_heard     = 1'b0;
	logic [RETRY_W-1:0] model_retries   = '0;
	logic               model_active    = 1'b0;

	sender_result_t owed_results [$];

	bit    evt_fixed;
	kind_t evt_fixed_kind;
	bit    evt_idle_on = 1'b1;
	bit    res_idle_on = 1'b1;
	int    mismatch_count = 0;
	int    quiet_cycles = 0;

	dir_step_t directed_steps [DIR_STEPS];
	reg_set_t  directed_regs [1:3];

	function automatic bit seq_after(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
		logic [SEQ_W-1:0] d;
		d = a - b;
		return (d != '0) && !d[SEQ_W-1];
	endfunction

	function automatic void owe(kind_t kind, logic [SEQ_W-1:0] seq, logic [LEN_W-1:0] len,
		logic rexmit);
		owed_results.push_back('{kind, seq, len, rexmit, 1'b0});
	endfunction

	// Closes a round: either the transfer is complete or the next burst goes out.
	function automatic int round_burst();
		logic [SEQ_W-1:0] rem;
		logic [SEQ_W-1:0] rmd;
		logic [SEQ_W-1:0] seq;
		logic [SEQ_W-1:0] mp;
		logic [SEQ_W-1:0] pay;
		logic rexmit;
		int n;
		rem = (model_acked >= cfg_file_len) ? '0 : cfg_file_len - model_acked;
		if (rem == '0) begin
			model_active = 1'b0;
			owe(KIND_COMPLETE, '0, '0, 1'b0);
			return 1;
		end
		mp = SEQ_W'(cfg_max_pay);
		if (mp == '0) begin
			mp = 1;
		end else if (mp > SEQ_W'(MAX_PAY_CAP)) begin
			mp = SEQ_W'(MAX_PAY_CAP);
		end
		rmd = (SEQ_W'(model_window) < rem) ? SEQ_W'(model_window) : rem;
		seq = model_next;
		n = 0;
		while (n < SEG_LIMIT && rmd != '0) begin
			pay = (rmd < mp) ? rmd : mp;
			rmd = rmd - pay;
			rexmit = 1'b1;
			if (seq_after(seq, model_highest)) begin
				model_highest = seq;
				rexmit = 1'b0;
			end
			owe(KIND_DATA, seq, pay[LEN_W-1:0], rexmit);
			seq = seq + pay;
			n++;
		end
		model_burst_end = seq;
		return n;
	endfunction

	// Reaction of the sender to one event; returns the number of results owed.
	function automatic int send_reaction(logic [MODE_W-1:0] mode, logic [SEQ_W-1:0] ackn,
		logic [WIN_W-1:0] ackw);
		int n;
		n = 0;
		if (mode == MODE_START) begin
			model_next      = cfg_start_seq;
			model_highest   = cfg_start_seq - 1;
			model_window    = cfg_init_win;
			model_acked     = '0;
			model_burst_end = cfg_start_seq;
			model_heard     = 1'b0;
			model_retries   = '0;
			model_active    = 1'b1;
			n = round_burst();
		end else if (!model_active) begin
			owe(KIND_IGNORED, '0, '0, 1'b0);
			n = 1;
		end else if (mode == MODE_ACK) begin
			model_heard = 1'b1;
			if (seq_after(ackn, model_next)) begin
				model_acked  = model_acked + (ackn - model_next);
				model_next   = ackn;
				model_window = ackw;
				owe(KIND_NEW_ACK, '0, '0, 1'b0);
				n = 1;
				if (ackn == model_burst_end) begin
					model_heard   = 1'b0;
					model_retries = '0;
					n += round_burst();
				end
			end else begin
				owe(KIND_DUP_ACK, '0, '0, 1'b0);
				n = 1;
			end
		end else if (mode == MODE_PEER_RST) begin
			model_active = 1'b0;
			owe(KIND_PEER_ABORT, '0, '0, 1'b0);
			n = 1;
		end else begin
			if (model_heard) begin
				model_retries = '0;
			end else if (model_retries < RETRY_MAX) begin
				model_retries = model_retries + 1'b1;
			end
			model_heard = 1'b0;
			if (model_retries >= cfg_retry_lim) begin
				model_active = 1'b0;
				owe(KIND_RST_SENT, '0, '0, 1'b0);
				n = 1;
			end else begin
				n = round_burst();
			end
		end
		if (n > 0) begin
			owed_results[owed_results.size() - 1].last = 1'b1;
		end
		return n;
	endfunction

	function automatic logic [WIN_W-1:0] rand_window();
		int unsigned pick;
		pick = $urandom_range(0, 15);
		if (pick == 0) begin
			return '0;
		end else if (pick == 1) begin
			return WIN_W'($urandom);
		end
		return WIN_W'($urandom_range(1, 6000));
	endfunction

	always @(posedge clk) begin : monitor
		sender_result_t want;
		int n;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (owed_results.size() == 0) begin
					$error("unexpected result: kind %0d seq %0h len %0d", res_ch.kind,
						res_ch.seq_number, res_ch.payload_len);
					mismatch_count++;
				end else begin
					want = owed_results.pop_front();
					if (res_ch.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, res_ch.kind);
						mismatch_count++;
					end
					if (res_ch.seq_number !== want.seq) begin
						$error("seq_number: expected %0h, got %0h", want.seq, res_ch.seq_number);
						mismatch_count++;
					end
					if (res_ch.payload_len !== want.len) begin
						$error("payload_len: expected %0d, got %0d", want.len, res_ch.payload_len);
						mismatch_count++;
					end
					if (res_ch.retransmit !== want.rexmit) begin
						$error("retransmit: expected %0d, got %0d", want.rexmit, res_ch.retransmit);
						mismatch_count++;
					end
					if (res_ch.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, res_ch.last);
						mismatch_count++;
					end
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					CFG_FILE_LENGTH: begin
						cfg_file_len = cfg_ch.data;
					end
					CFG_START_SEQUENCE: begin
						cfg_start_seq = cfg_ch.data;
					end
					CFG_INITIAL_WINDOW: begin
						cfg_init_win = cfg_ch.data[WIN_W-1:0];
					end
					CFG_MAX_PAYLOAD: begin
						cfg_max_pay = cfg_ch.data[LEN_W-1:0];
					end
					CFG_RETRY_LIMIT: begin
						cfg_retry_lim = cfg_ch.data[RETRY_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (evt_ch.valid && evt_ch.ready) begin
				n = send_reaction(evt_ch.mode, evt_ch.ack_number, evt_ch.ack_window);
				if (evt_fixed) begin
					repeat (n) void'(owed_results.pop_back());
					owed_results.push_back('{evt_fixed_kind, '0, '0, 1'b0, 1'b1});
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("window_sender_segmenter: mismatch");
				$finish;
			end
		end
	end

	initial begin : result_ready_gen
		int unsigned gap;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = res_idle_on ? $urandom_range(0, 5) : 0;
			@(negedge clk);
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic load_regs(reg_set_t r);
		write_reg(CFG_FILE_LENGTH, r.file_len);
		write_reg(CFG_START_SEQUENCE, r.start_seq);
		write_reg(CFG_INITIAL_WINDOW, r.init_win);
		write_reg(CFG_MAX_PAYLOAD, r.max_pay);
		write_reg(CFG_RETRY_LIMIT, r.retry_lim);
	endtask

	// Events may leave the block busy with no result owed, so the pause
	// after the queue drains covers a full event.
	task automatic settle_block();
		@(negedge clk);
		evt_ch.valid <= 1'b0;
		while (owed_results.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic idle_before_event();
		int unsigned gap;
		gap = evt_idle_on ? $urandom_range(0, 5) : 0;
		@(negedge clk);
		if (gap > 0) begin
			evt_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drive_event(logic [MODE_W-1:0] mode, logic [SEQ_W-1:0] ackn,
		logic [WIN_W-1:0] ackw, bit fixed, kind_t kind);
		evt_ch.valid      <= 1'b1;
		evt_ch.mode       <= mode;
		evt_ch.ack_number <= ackn;
		evt_ch.ack_window <= ackw;
		evt_fixed         <= fixed;
		evt_fixed_kind    <= kind;
		do @(posedge clk); while (!evt_ch.ready);
	endtask

	initial begin : stimulus
		reg_set_t regs;
		int cur_phase;
		int counted;
		int done;
		int phase_items;
		int unsigned pick;
		logic [MODE_W-1:0] mode;
		logic [SEQ_W-1:0] ackn;
		logic [SEQ_W-1:0] span;
		logic [WIN_W-1:0] ackw;

		evt_ch.valid      = 1'b0;
		evt_ch.mode       = MODE_START;
		evt_ch.ack_number = '0;
		evt_ch.ack_window = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = CFG_FILE_LENGTH;
		cfg_ch.data       = '0;
		evt_fixed         = 1'b0;
		evt_fixed_kind    = KIND_DATA;

		directed_regs[1] = '{32'd5000, 32'hFFFF_FF00, 32'd3000, 32'd1024, 32'd2};
		directed_regs[2] = '{32'h8000_0000, 32'd100, 32'd5, 32'd0, 32'd0};
		directed_regs[3] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF};
		directed_steps = '{
			'{0, MODE_ACK,      32'hFFFF_FFFF, 16'hFFFF, 1'b1, KIND_IGNORED},
			'{0, MODE_PEER_RST, 32'h0,         16'h0,    1'b1, KIND_IGNORED},
			'{0, MODE_TIMEOUT,  32'h0,         16'h0,    1'b1, KIND_IGNORED},
			'{0, MODE_START,    32'h0,         16'h0,    1'b1, KIND_COMPLETE},
			'{1, MODE_START,    32'h0,         16'h0,    1'b0, KIND_DATA},
			'{1, MODE_ACK,      32'hFFFF_FF00, 16'h0,    1'b1, KIND_DUP_ACK},
			'{1, MODE_ACK,      32'h0000_0300, 16'hFFFF, 1'b1, KIND_NEW_ACK},
			'{1, MODE_ACK,      32'h0000_0AB8, 16'hFFFF, 1'b0, KIND_DATA},
			'{1, MODE_TIMEOUT,  32'h0,         16'h0,    1'b0, KIND_DATA},
			'{1, MODE_TIMEOUT,  32'h0,         16'h0,    1'b1, KIND_RST_SENT},
			'{1, MODE_ACK,      32'h1234_5678, 16'h1234, 1'b1, KIND_IGNORED},
			'{1, MODE_START,    32'h0,         16'h0,    1'b0, KIND_DATA},
			'{1, MODE_PEER_RST, 32'h0,         16'h0,    1'b1, KIND_PEER_ABORT},
			'{1, MODE_START,    32'h0,         16'h0,    1'b0, KIND_DATA},
			'{1, MODE_ACK,      32'h7FFF_FEFF, 16'd100,  1'b1, KIND_NEW_ACK},
			'{1, MODE_TIMEOUT,  32'h0,         16'h0,    1'b1, KIND_COMPLETE},
			'{2, MODE_START,    32'h0,         16'h0,    1'b0, KIND_DATA},
			'{2, MODE_ACK,      32'd102,       16'd7,    1'b1, KIND_NEW_ACK},
			'{2, MODE_TIMEOUT,  32'h0,         16'h0,    1'b1, KIND_RST_SENT},
			'{2, MODE_START,    32'h0,         16'h0,    1'b0, KIND_DATA},
			'{2, MODE_TIMEOUT,  32'h0,         16'h0,    1'b1, KIND_RST_SENT},
			'{3, MODE_START,    32'h0,         16'h0,    1'b0, KIND_DATA},
			'{3, MODE_ACK,      32'h0000_3FFF, 16'h0,    1'b1, KIND_NEW_ACK},
			'{3, MODE_TIMEOUT,  32'h0,         16'h0,    1'b0, KIND_DATA},
			'{3, MODE_ACK,      32'h0000_4000, 16'd10,   1'b1, KIND_NEW_ACK}
		};

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		cur_phase = 0;
		foreach (directed_steps[k]) begin
			if (directed_steps[k].phase != cur_phase) begin
				settle_block();
				cur_phase = directed_steps[k].phase;
				load_regs(directed_regs[cur_phase]);
			end
			idle_before_event();
			drive_event(directed_steps[k].mode, directed_steps[k].ackn, directed_steps[k].ackw,
				directed_steps[k].fixed, directed_steps[k].kind);
		end

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			settle_block();
			pick = $urandom_range(0, 9);
			regs.file_len = (pick == 0) ? 32'd0 : (pick == 1) ? $urandom :
				$urandom_range(1, 12000);
			regs.start_seq = $urandom;
			pick = $urandom_range(0, 9);
			regs.init_win = (pick == 0) ? 32'd0 : (pick == 1) ? 32'd65535 :
				(pick == 2) ? $urandom : $urandom_range(1, 6000);
			pick = $urandom_range(0, 9);
			regs.max_pay = (pick == 0) ? 32'd0 : (pick == 1) ? $urandom :
				(pick == 2) ? 32'd1024 : $urandom_range(1, 1024);
			regs.retry_lim = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 5);
			load_regs(regs);
			evt_idle_on = ($urandom_range(0, 3) != 0);
			res_idle_on = ($urandom_range(0, 3) != 0);
			phase_items = $urandom_range(15, 50);
			done = 0;
			while (done < phase_items && counted < RANDOM_ITEMS) begin
				idle_before_event();
				mode = MODE_ACK;
				ackn = $urandom;
				ackw = WIN_W'($urandom);
				pick = $urandom_range(0, 99);
				span = model_burst_end - model_next;
				if (!model_active) begin
					if (pick < 80) begin
						mode = MODE_START;
					end else begin
						mode = MODE_W'($urandom_range(1, 3));
					end
				end else if (pick < 40) begin
					ackw = rand_window();
					if (seq_after(model_burst_end, model_next)) begin
						ackn = model_burst_end;
					end else begin
						ackn = model_next + $urandom_range(1, 3000);
					end
				end else if (pick < 60) begin
					ackw = rand_window();
					if (seq_after(model_burst_end, model_next) && span > 1) begin
						ackn = model_next + $urandom_range(1, span - 1);
					end else begin
						ackn = model_next + $urandom_range(1, 3000);
					end
				end else if (pick < 70) begin
					ackn = model_next - $urandom_range(0, 2000);
				end else if (pick < 85) begin
					mode = MODE_TIMEOUT;
				end else if (pick < 90) begin
					mode = MODE_PEER_RST;
				end else if (pick < 95) begin
					mode = MODE_START;
				end
				if (model_active || mode == MODE_START) begin
					done++;
					counted++;
				end
				drive_event(mode, ackn, ackw, 1'b0, KIND_DATA);
			end
		end
		settle_block();

		if (mismatch_count == 0) begin
			$display("window_sender_segmenter: match");
		end else begin
			$display("window_sender_segmenter: mismatch");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/wss_pkg.sv
design/wss_evt_if.sv
design/wss_res_if.sv
design/wss_cfg_if.sv
design/wss_ctrl.sv
design/wss_datapath.sv
design/window_sender_segmenter.sv
tb/tb_window_sender_segmenter.sv
